// ===== rtl/h264_annexb_nal_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// h264_annexb_nal_scanner_defines.svh
// Assertion macros for the Annex B NAL scanner. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef H264_ANNEXB_NAL_SCANNER_DEFINES_SVH
`define H264_ANNEXB_NAL_SCANNER_DEFINES_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle
`define NS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed");
// Antecedent implies consequent in the next cycle
`define NS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed");
`else
`define NS_ASSERT_SAME(lbl, ante, cons)
`define NS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/h264ns_pkg.sv =====
// ----------------------------------------------------------------------------
// h264ns_pkg
// Shared types and constants of the Annex B NAL scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h264ns_pkg;

  // NAL unit types of interest (header AND 0x1F)
  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  // Start code bytes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Result kinds on tuser
  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Queue depth between front and back
  localparam int FIFO_DEPTH = 4;

  // Output tdata width: 28 payload bits padded to whole bytes
  localparam int OUT_DATA_W = 32;

  // Sticky flags of the current buffer
  typedef struct packed {
    logic idr;
    logic pps;
    logic sps;
  } nal_flags_t;

  // Everything one byte produces: an optional SPS event and an optional summary
  typedef struct packed {
    logic       ev_valid;
    logic       sum_valid;
    nal_flags_t ev_flags;
    nal_flags_t sum_flags;
    logic [7:0] profile;
    logic [7:0] constraint_flags;
    logic [7:0] level;
    logic       event_direction;
  } bundle_t;

endpackage

// ===== rtl/h264ns_front.sv =====
// ----------------------------------------------------------------------------
// h264ns_front
// Byte scanner: start code detection, NAL header typing, SPS capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h264ns_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,   // byte transfer this cycle
  input  logic [7:0]           byte_in,
  input  logic                 end_of_buffer,
  input  logic                 direction,
  output logic                 push,
  output h264ns_pkg::bundle_t  bundle
);

  // SPS capture sequencer, one-hot
  typedef enum logic [3:0] {
    CAP_IDLE       = 4'b0001,
    CAP_PROFILE    = 4'b0010,
    CAP_CONSTRAINT = 4'b0100,
    CAP_LEVEL      = 4'b1000
  } cap_state_t;

  cap_state_t             cap_state, cap_state_next;
  logic [1:0]             zero_run, zero_run_next;
  logic                   await_header, await_header_next;
  h264ns_pkg::nal_flags_t buffer_flags, buffer_flags_next;
  logic [7:0]             cap_profile;
  logic [7:0]             cap_constraint;
  logic [1:0]             seen_per_dir;
  logic [23:0]            stored_sps [2];

  logic [23:0]            sps_value;
  logic                   sps_new;
  logic [4:0]             nal_type;

  assign sps_value = {cap_profile, cap_constraint, byte_in};
  assign nal_type  = byte_in[4:0];
  assign sps_new   = (cap_state == CAP_LEVEL) &&
                     (!seen_per_dir[direction] || (stored_sps[direction] != sps_value));

  // Next-state logic of the scanner
  always_comb begin
    cap_state_next    = cap_state;
    zero_run_next     = zero_run;
    await_header_next = await_header;
    buffer_flags_next = buffer_flags;

    case (cap_state)
      CAP_IDLE:       cap_state_next = CAP_IDLE;
      CAP_PROFILE:    cap_state_next = CAP_CONSTRAINT;
      CAP_CONSTRAINT: cap_state_next = CAP_LEVEL;
      CAP_LEVEL:      cap_state_next = CAP_IDLE;
      default:        cap_state_next = CAP_IDLE;
    endcase

    if (await_header) begin
      await_header_next = 1'b0;
      zero_run_next     = 2'd0;
      if (nal_type == h264ns_pkg::NAL_TYPE_SPS) begin
        buffer_flags_next.sps = 1'b1;
        cap_state_next        = CAP_PROFILE;
      end else if (nal_type == h264ns_pkg::NAL_TYPE_PPS) begin
        buffer_flags_next.pps = 1'b1;
      end else if (nal_type == h264ns_pkg::NAL_TYPE_IDR) begin
        buffer_flags_next.idr = 1'b1;
      end
    end else if (byte_in == h264ns_pkg::BYTE_ZERO) begin
      if (zero_run != 2'd2) begin
        zero_run_next = zero_run + 2'd1;
      end
    end else if (byte_in == h264ns_pkg::BYTE_ONE && zero_run == 2'd2) begin
      await_header_next = 1'b1;
      zero_run_next     = 2'd0;
    end else begin
      zero_run_next = 2'd0;
    end
  end

  // Result bundle for the queue
  always_comb begin
    bundle.ev_valid         = sps_new;
    bundle.sum_valid        = end_of_buffer;
    bundle.ev_flags         = buffer_flags;
    bundle.sum_flags        = buffer_flags_next;
    bundle.profile          = cap_profile;
    bundle.constraint_flags = cap_constraint;
    bundle.level            = byte_in;
    bundle.event_direction  = direction;
  end

  assign push = in_valid && (sps_new || end_of_buffer);

  // Control state; buffer end clears the per-buffer part
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_state    <= CAP_IDLE;
      zero_run     <= 2'd0;
      await_header <= 1'b0;
      buffer_flags <= '0;
      seen_per_dir <= 2'b00;
    end else if (in_valid) begin
      if (end_of_buffer) begin
        cap_state    <= CAP_IDLE;
        zero_run     <= 2'd0;
        await_header <= 1'b0;
        buffer_flags <= '0;
      end else begin
        cap_state    <= cap_state_next;
        zero_run     <= zero_run_next;
        await_header <= await_header_next;
        buffer_flags <= buffer_flags_next;
      end
      if (sps_new) begin
        seen_per_dir[direction] <= 1'b1;
      end
    end
  end

  // Captured bytes and stored SPS values, guarded by the sequencer and seen bits
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (cap_state == CAP_PROFILE) begin
        cap_profile <= byte_in;
      end
      if (cap_state == CAP_CONSTRAINT) begin
        cap_constraint <= byte_in;
      end
      if (sps_new) begin
        stored_sps[direction] <= sps_value;
      end
    end
  end

endmodule

// ===== rtl/h264ns_queue.sv =====
// ----------------------------------------------------------------------------
// h264ns_queue
// Small FIFO of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h264ns_queue #(
  parameter int DEPTH = h264ns_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  h264ns_pkg::bundle_t         push_data,
  input  logic                        pop,
  output logic                        not_empty,
  output logic                        full,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  output h264ns_pkg::bundle_t         head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  h264ns_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;

  logic do_push;
  logic do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/h264ns_back.sv =====
// ----------------------------------------------------------------------------
// h264ns_back
// Output stage: splits each bundle into one or two result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module h264ns_back #(
  parameter int DATA_W = h264ns_pkg::OUT_DATA_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  h264ns_pkg::bundle_t  q_head,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  logic ev_sent;          // event of the head bundle already went out
  logic load;
  logic send_event;

  logic [DATA_W-1:0] beat_data;
  logic              beat_last;
  logic              beat_kind;

  assign load       = q_valid && (!m_tvalid || m_tready);
  assign send_event = q_head.ev_valid && !ev_sent;
  assign q_pop      = load && !(send_event && q_head.sum_valid);

  // Pick the beat: event first, then summary
  always_comb begin
    if (send_event) begin
      beat_kind = h264ns_pkg::KIND_EVENT;
      beat_last = !q_head.sum_valid;
      beat_data = DATA_W'({q_head.event_direction, q_head.level,
                           q_head.constraint_flags, q_head.profile,
                           q_head.ev_flags.idr, q_head.ev_flags.pps,
                           q_head.ev_flags.sps});
    end else begin
      beat_kind = h264ns_pkg::KIND_SUMMARY;
      beat_last = 1'b1;
      beat_data = DATA_W'({25'd0, q_head.sum_flags.idr, q_head.sum_flags.pps,
                           q_head.sum_flags.sps});
    end
  end

  // Output register and split tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      ev_sent  <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        ev_sent  <= !q_pop;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_data;
      m_tlast <= beat_last;
      m_tuser <= beat_kind;
    end
  end

endmodule

// ===== rtl/h264_annexb_nal_scanner.sv =====
// ----------------------------------------------------------------------------
// h264_annexb_nal_scanner
// Annex B byte stream scanner: NAL type flags, SPS change events, summaries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one byte per transfer; s_tlast marks the last byte of a
//   buffer, s_tuser gives the direction (0 received, 1 sent).
//   Output stream: one result per transfer. m_tuser is the kind (0 SPS event,
//   1 buffer summary); m_tlast marks the last result caused by one byte.
//   Throughput: one byte per clock while the queue is not full. A byte
//   yields zero, one or two results; the scanner decides in the cycle of
//   the byte transfer and writes a bundle into a FIFO_DEPTH-entry queue.
//   Each bundle is registered in the queue and each result in the output
//   stage. A byte with two results (SPS event on the last byte) needs two
//   output transfers; the queue absorbs these while input continues.
//   Stall: when the receiver holds m_tready low the queue fills, and once
//   it is full s_tready drops until an entry drains.
//   Reset: clears scanner state, queue and output stage; stored SPS values of
//   both directions are forgotten, so the next SPS of each direction reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "h264_annexb_nal_scanner_defines.svh"

module h264_annexb_nal_scanner #(
  parameter int FIFO_DEPTH = h264ns_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_buffer
  input  logic        s_tuser,   // [0] direction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [h264ns_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] found_sps, [1] found_pps, [2] found_idr, [10:3] profile,
  // [18:11] constraint_flags, [26:19] level, [27] event_direction, [31:28] zero
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // [0] kind
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic                      in_xfer;
  logic                      push;
  h264ns_pkg::bundle_t       bundle;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  logic [CNT_W-1:0]          q_count;
  h264ns_pkg::bundle_t       q_head;

  assign s_tready = !q_full;
  assign in_xfer  = s_tvalid && s_tready;

  // Scanner
  h264ns_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_xfer),
    .byte_in       (s_tdata),
    .end_of_buffer (s_tlast),
    .direction     (s_tuser),
    .push          (push),
    .bundle        (bundle)
  );

  // Result queue
  h264ns_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .count     (q_count),
    .head      (q_head)
  );

  // Output stage
  h264ns_back #(
    .DATA_W (h264ns_pkg::OUT_DATA_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Checks
  `NS_ASSERT_SAME(a_no_push_when_full, push, !q_full)
  `NS_ASSERT_SAME(a_count_in_range, 1'b1, q_count <= CNT_W'(FIFO_DEPTH))
  `NS_ASSERT_SAME(a_summary_ends_run, m_tvalid && m_tuser, m_tlast)
  `NS_ASSERT_NEXT(a_split_event_then_summary, m_tvalid && m_tready && !m_tlast,
                  m_tvalid && m_tuser)

endmodule
